### sv/bitstream_pack_unpack_buffer_assert.svh
// Assertion macros for the bit-stream pack/unpack buffer.
// They expect clk and the active-high synchronous rst to be in scope where used.
`ifndef BITSTREAM_PACK_UNPACK_BUFFER_ASSERT_SVH
`define BITSTREAM_PACK_UNPACK_BUFFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPUB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPUB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bpub_pkg.sv
// Shared types, constants and helper functions of the bit-stream pack/unpack buffer.
// Depends on nothing; the design files refer to it by scoped names, the testbench imports it.
package bpub_pkg;

  localparam int STORE_BYTES_DEFAULT = 1024;
  localparam int WORD_BYTES = 8;
  localparam int WORD_W     = 64;
  localparam int WINDOW_W   = 2 * WORD_W;
  localparam int OFF_W      = 6;
  localparam int FIELD_MAX  = 32;
  localparam int PREFIX_W   = 6;
  localparam int WLEN_W     = 6;
  localparam int WDATA_W    = FIELD_MAX + PREFIX_W;
  localparam int CURSOR_W   = 11;
  localparam int RSP_DEPTH  = 4;
  localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);
  localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);

  typedef enum logic [2:0] {
    MODE_WRITE     = 3'd0,
    MODE_READ      = 3'd1,
    MODE_WRITE_VAR = 3'd2,
    MODE_READ_VAR  = 3'd3,
    MODE_ALIGN     = 3'd4,
    MODE_REWIND    = 3'd5,
    MODE_TO_END    = 3'd6,
    MODE_CLEAR     = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_DATA   = 2'd1,
    STATUS_BAD_WIDTH = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  typedef logic [CURSOR_W-1:0]  cursor_t;
  typedef logic [RSP_CNT_W-1:0] rsp_cnt_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] value;
    logic [5:0]  width;
  } cmd_t;

  typedef struct packed {
    logic [31:0]   read_data;
    status_t       status;
    cursor_t       byte_cursor;
    logic [2:0]    bit_cursor;
  } rsp_t;

  // Number of significant bits of a word, 0 to 32.
  function automatic logic [WLEN_W-1:0] sig_bits(input logic [31:0] v);
    logic [WLEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        n = WLEN_W'(i + 1);
      end
    end
    return n;
  endfunction

  // Ones in the n lowest bits; all ones for n of 32 or more.
  function automatic logic [31:0] low_mask(input logic [WLEN_W-1:0] n);
    logic [32:0] m;
    m = (33'd1 << n) - 33'd1;
    return m[31:0];
  endfunction

  function automatic logic [31:0] sat_to(input logic [31:0] v, input logic [WLEN_W-1:0] n);
    logic [31:0] m;
    m = low_mask(n);
    return (v > m) ? m : v;
  endfunction

endpackage

### sv/bpub_bank.sv
// One bank of 64-bit store words with a write port and a registered read port.
// Depends on bpub_pkg for the word width.
module bpub_bank #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [bpub_pkg::WORD_W-1:0]  wdata,
  input  logic [AW-1:0]                raddr,
  output logic [bpub_pkg::WORD_W-1:0]  rdata
);

  logic [bpub_pkg::WORD_W-1:0] mem [DEPTH];

  // A read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bpub_rsp_fifo.sv
// Small response queue between the store pipeline and the response channel.
// Depends on bpub_pkg for the response type and queue depth.
module bpub_rsp_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bpub_pkg::rsp_t      push_data,
  input  logic                pop,
  output logic                valid,
  output bpub_pkg::rsp_t      data,
  output bpub_pkg::rsp_cnt_t  count
);

  localparam int PTR_W = bpub_pkg::RSP_PTR_W;

  bpub_pkg::rsp_t     entry [bpub_pkg::RSP_DEPTH];
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   tail;
  logic               do_pop;

  assign valid  = (count != '0);
  assign data   = entry[head];
  assign do_pop = pop && valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(bpub_pkg::RSP_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= ptr_inc(tail);
      end
      if (do_pop) begin
        head <= ptr_inc(head);
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[tail] <= push_data;
    end
  end

endmodule

### sv/bitstream_pack_unpack_buffer.sv
// Channel  Dir  Handshake              Payload
// cmd      in   cmd_valid / cmd_ready  bpub_pkg::cmd_t (mode, value, width)
// rsp      out  rsp_valid / rsp_ready  bpub_pkg::rsp_t (read_data, status, cursors)
//
// One command per cycle unless stalled; a variable-length read holds the next transfer
// back, because its cursor comes from the length prefix read out of the store.
// A response is pushed into the queue by the memory stage (bank read, then merge and write
// back). Reset clears the cursor and filled size at once; no clearing pass runs, as bytes
// at or above the filled size are never returned. The command side also stalls when the
// four-entry response queue could not take what is in flight.
// Depends on bpub_pkg, bpub_bank, bpub_rsp_fifo and the assertion macro header.
`include "bitstream_pack_unpack_buffer_assert.svh"

module bitstream_pack_unpack_buffer #(
  parameter int STORE_BYTES = bpub_pkg::STORE_BYTES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  bpub_pkg::cmd_t  cmd,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output bpub_pkg::rsp_t  rsp
);

  localparam int BYTE_W     = $clog2(STORE_BYTES + 1);
  localparam int POS_W      = BYTE_W + 3;
  localparam int SUM_W      = POS_W + 1;
  localparam int WIDX_W     = POS_W - bpub_pkg::OFF_W;
  localparam int NUM_WORDS  = (STORE_BYTES + bpub_pkg::WORD_BYTES - 1) / bpub_pkg::WORD_BYTES;
  localparam int BANK_DEPTH = (NUM_WORDS + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int WORD_W     = bpub_pkg::WORD_W;
  localparam int WINDOW_W   = bpub_pkg::WINDOW_W;
  localparam int WLEN_W     = bpub_pkg::WLEN_W;
  localparam int WDATA_W    = bpub_pkg::WDATA_W;
  localparam logic [SUM_W-1:0] LIMIT = SUM_W'(STORE_BYTES * 8);

  typedef struct packed {
    bpub_pkg::mode_t    mode;
    bpub_pkg::status_t  status;
    logic               write;
    logic [WLEN_W-1:0]  wlen;
    logic [WDATA_W-1:0] wdata;
    logic [WLEN_W-1:0]  rlen;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   pos_after;
    logic [BANK_AW-1:0] even_addr;
    logic [BANK_AW-1:0] odd_addr;
  } stage_t;

  // Cursor and fill state.
  logic [BYTE_W-1:0] byte_pos, byte_pos_next;
  logic [2:0]        bit_pos, bit_pos_next;
  logic [BYTE_W-1:0] filled, filled_next;

  // Command stage.
  logic                 cmd_fire;
  logic [POS_W-1:0]     pos;
  logic [SUM_W-1:0]     pos_ext;
  logic [SUM_W-1:0]     filled_bits;
  logic [WLEN_W-1:0]    n_sig;
  logic [WLEN_W-1:0]    wlen;
  logic [WDATA_W-1:0]   wdata;
  logic [SUM_W-1:0]     w_end;
  logic [SUM_W-1:0]     w_round;
  logic [BYTE_W:0]      end_bytes;
  logic [SUM_W-1:0]     r_end;
  logic [SUM_W-1:0]     pre_end;
  bpub_pkg::status_t    s1_status;
  logic                 s1_write;
  logic [WIDX_W-1:0]    word_idx;
  logic [WIDX_W:0]      word_inc;
  logic [BANK_AW-1:0]   even_raddr;
  logic [BANK_AW-1:0]   odd_raddr;

  // Memory stage.
  logic                 s2_valid;
  stage_t               s2;
  logic [WORD_W-1:0]    b0_rdata, b1_rdata;
  logic [WORD_W-1:0]    b0_word, b1_word;
  logic                 b0_we, b1_we;
  logic [WORD_W-1:0]    b0_wdata, b1_wdata;
  logic                 fwd0_we, fwd1_we;
  logic [BANK_AW-1:0]   fwd0_addr, fwd1_addr;
  logic [WORD_W-1:0]    fwd0_data, fwd1_data;
  logic [bpub_pkg::OFF_W-1:0] off;
  logic                 odd_first;
  logic [WINDOW_W-1:0]  window;
  logic [WDATA_W-1:0]   field;
  logic [6:0]           end_off;
  logic [6:0]           end_off_up;
  logic [6:0]           rup;
  logic [WINDOW_W-1:0]  upper_mask;
  logic [WINDOW_W-1:0]  lower_mask;
  logic [WINDOW_W-1:0]  clear_mask;
  logic [WINDOW_W-1:0]  merged;
  logic                 lo_we, hi_we;
  logic [WLEN_W-1:0]    rv_len;
  logic [SUM_W-1:0]     rv_start;
  logic [SUM_W-1:0]     rv_end;
  bpub_pkg::status_t    rv_status;
  logic                 rv_commit;
  bpub_pkg::status_t    out_status;
  logic [31:0]          out_data;
  logic [POS_W-1:0]     out_pos;
  bpub_pkg::rsp_t       rsp_item;
  bpub_pkg::rsp_cnt_t   fifo_count;

  // ---------------------------------------------------------------- command stage

  assign cmd_fire = cmd_valid && cmd_ready;

  // A variable-length read sitting in the memory stage still owns the cursor.
  assign cmd_ready = !(s2_valid && (s2.mode == bpub_pkg::MODE_READ_VAR)) &&
                     ((fifo_count + bpub_pkg::rsp_cnt_t'(s2_valid)) <
                      bpub_pkg::rsp_cnt_t'(bpub_pkg::RSP_DEPTH));

  assign pos         = {byte_pos, bit_pos};
  assign pos_ext     = SUM_W'(pos);
  assign filled_bits = SUM_W'({filled, 3'b000});
  assign n_sig       = bpub_pkg::sig_bits(cmd.value);

  always_comb begin
    if (cmd.mode == bpub_pkg::MODE_WRITE_VAR) begin
      wlen  = WLEN_W'(bpub_pkg::PREFIX_W) + n_sig;
      wdata = {cmd.value, n_sig};
    end else begin
      wlen  = cmd.width;
      wdata = WDATA_W'(bpub_pkg::sat_to(cmd.value, cmd.width));
    end
  end

  assign w_end     = pos_ext + SUM_W'(wlen);
  assign w_round   = w_end + SUM_W'(7);
  assign end_bytes = w_round[SUM_W-1:3];
  assign r_end     = pos_ext + SUM_W'(cmd.width);
  assign pre_end   = pos_ext + SUM_W'(bpub_pkg::PREFIX_W);

  always_comb begin
    s1_status     = bpub_pkg::STATUS_OK;
    s1_write      = 1'b0;
    byte_pos_next = byte_pos;
    bit_pos_next  = bit_pos;
    filled_next   = filled;
    case (cmd.mode)
      bpub_pkg::MODE_WRITE, bpub_pkg::MODE_WRITE_VAR: begin
        if ((cmd.mode == bpub_pkg::MODE_WRITE) &&
            (cmd.width > WLEN_W'(bpub_pkg::FIELD_MAX))) begin
          s1_status = bpub_pkg::STATUS_BAD_WIDTH;
        end else if (wlen != '0) begin
          if (w_end > LIMIT) begin
            s1_status = bpub_pkg::STATUS_FULL;
          end else begin
            s1_write                     = 1'b1;
            {byte_pos_next, bit_pos_next} = POS_W'(w_end);
            if (end_bytes > {1'b0, filled}) begin
              filled_next = end_bytes[BYTE_W-1:0];
            end
          end
        end
      end
      bpub_pkg::MODE_READ: begin
        if (cmd.width != '0) begin
          if (byte_pos >= filled) begin
            s1_status = bpub_pkg::STATUS_NO_DATA;
          end else if (cmd.width > WLEN_W'(bpub_pkg::FIELD_MAX)) begin
            s1_status = bpub_pkg::STATUS_BAD_WIDTH;
          end else if (r_end > filled_bits) begin
            s1_status = bpub_pkg::STATUS_NO_DATA;
          end else begin
            {byte_pos_next, bit_pos_next} = POS_W'(r_end);
          end
        end
      end
      bpub_pkg::MODE_READ_VAR: begin
        // Only the prefix can be checked here; the rest waits for the store data.
        if (byte_pos >= filled) begin
          s1_status = bpub_pkg::STATUS_NO_DATA;
        end else if (pre_end > filled_bits) begin
          s1_status = bpub_pkg::STATUS_NO_DATA;
        end
      end
      bpub_pkg::MODE_ALIGN: begin
        if (bit_pos != '0) begin
          byte_pos_next = byte_pos + 1'b1;
          bit_pos_next  = '0;
        end
      end
      bpub_pkg::MODE_REWIND: begin
        byte_pos_next = '0;
        bit_pos_next  = '0;
      end
      bpub_pkg::MODE_TO_END: begin
        byte_pos_next = filled;
        bit_pos_next  = '0;
      end
      bpub_pkg::MODE_CLEAR: begin
        byte_pos_next = '0;
        bit_pos_next  = '0;
        filled_next   = '0;
      end
      default: begin
      end
    endcase
  end

  // Word w sits in bank (w & 1); the window is words w and w + 1, one from each bank.
  assign word_idx   = pos[POS_W-1:bpub_pkg::OFF_W];
  assign word_inc   = {1'b0, word_idx} + 1'b1;
  assign even_raddr = BANK_AW'(word_inc >> 1);
  assign odd_raddr  = BANK_AW'(word_idx >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= '0;
      bit_pos  <= '0;
      filled   <= '0;
    end else if (cmd_fire && (cmd.mode != bpub_pkg::MODE_READ_VAR)) begin
      byte_pos <= byte_pos_next;
      bit_pos  <= bit_pos_next;
      filled   <= filled_next;
    end else if (rv_commit) begin
      {byte_pos, bit_pos} <= out_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= cmd_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s2.mode      <= cmd.mode;
      s2.status    <= s1_status;
      s2.write     <= s1_write;
      s2.wlen      <= wlen;
      s2.wdata     <= wdata;
      s2.rlen      <= cmd.width;
      s2.pos       <= pos;
      s2.pos_after <= {byte_pos_next, bit_pos_next};
      s2.even_addr <= even_raddr;
      s2.odd_addr  <= odd_raddr;
    end
  end

  // ---------------------------------------------------------------- store banks

  bpub_bank #(
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_bank_even (
    .clk   (clk),
    .we    (b0_we),
    .waddr (s2.even_addr),
    .wdata (b0_wdata),
    .raddr (even_raddr),
    .rdata (b0_rdata)
  );

  bpub_bank #(
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_bank_odd (
    .clk   (clk),
    .we    (b1_we),
    .waddr (s2.odd_addr),
    .wdata (b1_wdata),
    .raddr (odd_raddr),
    .rdata (b1_rdata)
  );

  // The bank read for this command was taken at the edge the previous command wrote,
  // so that write is forwarded over the stale word.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd0_we <= 1'b0;
      fwd1_we <= 1'b0;
    end else begin
      fwd0_we <= b0_we;
      fwd1_we <= b1_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd0_addr <= s2.even_addr;
    fwd0_data <= b0_wdata;
    fwd1_addr <= s2.odd_addr;
    fwd1_data <= b1_wdata;
  end

  // ---------------------------------------------------------------- memory stage

  assign b0_word = (fwd0_we && (fwd0_addr == s2.even_addr)) ? fwd0_data : b0_rdata;
  assign b1_word = (fwd1_we && (fwd1_addr == s2.odd_addr)) ? fwd1_data : b1_rdata;

  assign off       = s2.pos[bpub_pkg::OFF_W-1:0];
  assign odd_first = s2.pos[bpub_pkg::OFF_W];
  assign window    = odd_first ? {b0_word, b1_word} : {b1_word, b0_word};
  assign field     = WDATA_W'(window >> off);

  // A write replaces the bits from the cursor up to the end of the byte holding its
  // last bit: the field itself, then zeros above it.
  assign end_off    = {1'b0, off} + {1'b0, s2.wlen};
  assign end_off_up = end_off + 7'd7;
  assign rup        = {end_off_up[6:3], 3'b000};
  assign upper_mask = (WINDOW_W'(1) << rup) - WINDOW_W'(1);
  assign lower_mask = (WINDOW_W'(1) << off) - WINDOW_W'(1);
  assign clear_mask = upper_mask & ~lower_mask;
  assign merged     = (window & ~clear_mask) | (WINDOW_W'(s2.wdata) << off);

  assign lo_we    = s2_valid && s2.write && (|clear_mask[WORD_W-1:0]);
  assign hi_we    = s2_valid && s2.write && (|clear_mask[WINDOW_W-1:WORD_W]);
  assign b0_we    = odd_first ? hi_we : lo_we;
  assign b1_we    = odd_first ? lo_we : hi_we;
  assign b0_wdata = odd_first ? merged[WINDOW_W-1:WORD_W] : merged[WORD_W-1:0];
  assign b1_wdata = odd_first ? merged[WORD_W-1:0] : merged[WINDOW_W-1:WORD_W];

  assign rv_len   = field[bpub_pkg::PREFIX_W-1:0];
  assign rv_start = SUM_W'(s2.pos) + SUM_W'(bpub_pkg::PREFIX_W);
  assign rv_end   = rv_start + SUM_W'(rv_len);

  always_comb begin
    if (s2.status != bpub_pkg::STATUS_OK) begin
      rv_status = s2.status;
    end else if (rv_len > WLEN_W'(bpub_pkg::FIELD_MAX)) begin
      rv_status = bpub_pkg::STATUS_BAD_WIDTH;
    end else if (rv_len == '0) begin
      rv_status = bpub_pkg::STATUS_OK;
    end else if (rv_start[SUM_W-1:3] >= {1'b0, filled}) begin
      rv_status = bpub_pkg::STATUS_NO_DATA;
    end else if (rv_end > filled_bits) begin
      rv_status = bpub_pkg::STATUS_NO_DATA;
    end else begin
      rv_status = bpub_pkg::STATUS_OK;
    end
  end

  assign rv_commit = s2_valid && (s2.mode == bpub_pkg::MODE_READ_VAR) &&
                     (rv_status == bpub_pkg::STATUS_OK);

  always_comb begin
    out_status = s2.status;
    out_pos    = s2.pos_after;
    out_data   = '0;
    case (s2.mode)
      bpub_pkg::MODE_READ: begin
        out_data = field[31:0] & bpub_pkg::low_mask(s2.rlen);
      end
      bpub_pkg::MODE_READ_VAR: begin
        out_status = rv_status;
        out_data   = field[WDATA_W-1:bpub_pkg::PREFIX_W] & bpub_pkg::low_mask(rv_len);
        out_pos    = (rv_status == bpub_pkg::STATUS_OK) ? POS_W'(rv_end) : s2.pos;
      end
      default: begin
      end
    endcase
    if (out_status != bpub_pkg::STATUS_OK) begin
      out_data = '0;
    end
  end

  always_comb begin
    rsp_item.read_data   = out_data;
    rsp_item.status      = out_status;
    rsp_item.byte_cursor = bpub_pkg::cursor_t'(out_pos[POS_W-1:3]);
    rsp_item.bit_cursor  = out_pos[2:0];
  end

  bpub_rsp_fifo u_rsp_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (rsp_item),
    .pop       (rsp_ready),
    .valid     (rsp_valid),
    .data      (rsp),
    .count     (fifo_count)
  );

  // ---------------------------------------------------------------- assertions

  `BPUB_ASSERT_NOW(a_rv_interlock, s2_valid && (s2.mode == bpub_pkg::MODE_READ_VAR), !cmd_fire, "command accepted while a variable-length read owns the cursor")
  `BPUB_ASSERT_NOW(a_queue_space, s2_valid, fifo_count != bpub_pkg::rsp_cnt_t'(bpub_pkg::RSP_DEPTH), "response pushed into a full queue")
  `BPUB_ASSERT_NOW(a_cursor_in_fill, 1'b1, pos_ext <= filled_bits, "cursor beyond the filled part of the store")
  `BPUB_ASSERT_NEXT(a_stage_follows, cmd_fire, s2_valid, "accepted command did not reach the memory stage")

endmodule

### tb/sv/bitstream_pack_unpack_buffer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bit-stream pack/unpack buffer: a scoreboard class
// tracks the store, cursor and filled size and checks every response in order.
// Depends on bpub_pkg and the bitstream_pack_unpack_buffer top level.
module bitstream_pack_unpack_buffer_test;
  import bpub_pkg::*;

  localparam int STORE_BYTES = 1024;
  localparam int STORE_BITS  = STORE_BYTES * 8;
  localparam int RANDOM_CMDS = 400;
  localparam int QUIET_TAIL  = 60;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 200000;

  class bitstream_tracker;
    bit [7:0]    store_mem [STORE_BYTES];
    int unsigned cur_byte;
    int unsigned cur_bit;
    int unsigned filled;
    rsp_t        pending_rsps [$];
    int          errors;
    int          checked;
    int          mode_count [8];

    function new();
      foreach (store_mem[i]) store_mem[i] = '0;
      cur_byte = 0;
      cur_bit  = 0;
      filled   = 0;
      errors   = 0;
      checked  = 0;
      foreach (mode_count[i]) mode_count[i] = 0;
    endfunction

    function void set_cursor(int unsigned bits);
      cur_byte = bits >> 3;
      cur_bit  = bits & 7;
    endfunction

    function int unsigned count_sig_bits(bit [31:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 32; i++) begin
        if (v[i]) n = i + 1;
      end
      return n;
    endfunction

    function bit [31:0] saturate(bit [31:0] v, int unsigned n);
      longint unsigned top;
      if (n >= 32) return v;
      top = (64'd1 << n) - 1;
      return (v > top) ? 32'(top) : v;
    endfunction

    // Stores n bits LSB-first and clears the rest of the last byte touched.
    function void put_field(int unsigned pos, bit [31:0] v, int unsigned n);
      int unsigned stop;
      for (int unsigned i = 0; i < n; i++) begin
        store_mem[(pos + i) >> 3][(pos + i) & 7] = v[i];
      end
      stop = pos + n;
      if ((stop & 7) != 0 && (stop >> 3) < STORE_BYTES) begin
        store_mem[stop >> 3] = store_mem[stop >> 3] & 8'((1 << (stop & 7)) - 1);
      end
      if (((stop + 7) >> 3) > filled) filled = (stop + 7) >> 3;
    endfunction

    function bit [31:0] get_field(int unsigned pos, int unsigned n);
      bit [31:0] r;
      r = '0;
      for (int unsigned i = 0; i < n && i < 32; i++) begin
        if (((pos + i) >> 3) < STORE_BYTES) r[i] = store_mem[(pos + i) >> 3][(pos + i) & 7];
      end
      return r;
    endfunction

    function status_t read_status(int unsigned pos, int unsigned n);
      if (n == 0) return STATUS_OK;
      if ((pos >> 3) >= filled) return STATUS_NO_DATA;
      if (n > 32) return STATUS_BAD_WIDTH;
      if (pos + n > filled * 8) return STATUS_NO_DATA;
      return STATUS_OK;
    endfunction

    function rsp_t predict_response(cmd_t c);
      int unsigned pos;
      int unsigned w;
      int unsigned n;
      int unsigned len;
      bit [31:0]   data;
      status_t     st;
      rsp_t        r;
      pos  = cur_byte * 8 + cur_bit;
      w    = c.width;
      data = '0;
      st   = STATUS_OK;
      case (c.mode)
        MODE_WRITE: begin
          if (w > 32) begin
            st = STATUS_BAD_WIDTH;
          end else if (w != 0) begin
            if (pos + w > STORE_BITS) begin
              st = STATUS_FULL;
            end else begin
              put_field(pos, saturate(c.value, w), w);
              set_cursor(pos + w);
            end
          end
        end
        MODE_READ: begin
          st = read_status(pos, w);
          if (st == STATUS_OK && w != 0) begin
            data = get_field(pos, w);
            set_cursor(pos + w);
          end
        end
        MODE_WRITE_VAR: begin
          n = count_sig_bits(c.value);
          if (pos + PREFIX_W + n > STORE_BITS) begin
            st = STATUS_FULL;
          end else begin
            put_field(pos, n, PREFIX_W);
            put_field(pos + PREFIX_W, c.value, n);
            set_cursor(pos + PREFIX_W + n);
          end
        end
        MODE_READ_VAR: begin
          st = read_status(pos, PREFIX_W);
          if (st == STATUS_OK) begin
            len = get_field(pos, PREFIX_W);
            if (len > 32) begin
              st = STATUS_BAD_WIDTH;
            end else begin
              st = read_status(pos + PREFIX_W, len);
              if (st == STATUS_OK) begin
                data = get_field(pos + PREFIX_W, len);
                set_cursor(pos + PREFIX_W + len);
              end
            end
          end
        end
        MODE_ALIGN: begin
          if (cur_bit != 0) begin
            cur_byte++;
            cur_bit = 0;
          end
        end
        MODE_REWIND: set_cursor(0);
        MODE_TO_END: set_cursor(filled * 8);
        MODE_CLEAR: begin
          filled = 0;
          set_cursor(0);
        end
        default: ;
      endcase
      if (st != STATUS_OK) data = '0;
      r.read_data   = data;
      r.status      = st;
      r.byte_cursor = cursor_t'(cur_byte);
      r.bit_cursor  = 3'(cur_bit);
      return r;
    endfunction

    function void note_command(cmd_t c);
      mode_count[int'(c.mode)]++;
      pending_rsps.push_back(predict_response(c));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      bit   bad;
      if (pending_rsps.size() == 0) begin
        errors++;
        $display("%0t ns: response with none expected: read_data %h status %0d cursor %0d.%0d",
                 $time, got.read_data, got.status, got.byte_cursor, got.bit_cursor);
        return;
      end
      want = pending_rsps.pop_front();
      checked++;
      bad  = 1'b0;
      if (got.read_data !== want.read_data) begin
        bad = 1'b1;
        $display("%0t ns: read_data expected %h, got %h", $time, want.read_data, got.read_data);
      end
      if (got.status !== want.status) begin
        bad = 1'b1;
        $display("%0t ns: status expected %0d, got %0d", $time, want.status, got.status);
      end
      if (got.byte_cursor !== want.byte_cursor) begin
        bad = 1'b1;
        $display("%0t ns: byte_cursor expected %0d, got %0d", $time,
                 want.byte_cursor, got.byte_cursor);
      end
      if (got.bit_cursor !== want.bit_cursor) begin
        bad = 1'b1;
        $display("%0t ns: bit_cursor expected %0d, got %0d", $time,
                 want.bit_cursor, got.bit_cursor);
      end
      if (bad) errors++;
    endfunction

    function int pending();
      return pending_rsps.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  bitstream_tracker sb;
  bit  idle_on;
  bit  hold_receiver;
  int  sent;
  int  cycle_count;

  bitstream_pack_unpack_buffer #(
    .STORE_BYTES(STORE_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d responses outstanding",
               cycle_count, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp);
  end

  // Response side: random back-pressure bursts, plus one long hold-off so that the
  // response queue fills and the command side has to stall.
  initial begin
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        hold_receiver = 1'b0;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Offers one command from a falling edge until its transfer, then may go quiet.
  task automatic send_cmd(input cmd_t c);
    int gap;
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sb.note_command(c);
    sent++;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic issue(input mode_t m, input logic [31:0] v = '0, input logic [5:0] w = '0);
    cmd_t c;
    c.mode  = m;
    c.value = v;
    c.width = w;
    send_cmd(c);
  endtask

  // Values with a random number of leading zeros, so saturation and prefix lengths vary.
  function automatic logic [31:0] rand_value();
    return 32'($urandom) >> $urandom_range(0, 32);
  endfunction

  // Writes a short record from the start of the store and reads it back in the same shape.
  task automatic run_record();
    int    k;
    int    r;
    mode_t steps [8];
    int    widths [8];
    k = $urandom_range(1, 8);
    if ($urandom_range(0, 1) == 0) issue(MODE_CLEAR);
    else issue(MODE_REWIND);
    for (int i = 0; i < k; i++) begin
      r = $urandom_range(0, 4);
      steps[i]  = (r < 2) ? MODE_WRITE : ((r < 4) ? MODE_WRITE_VAR : MODE_ALIGN);
      widths[i] = ($urandom_range(0, 15) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
      issue(steps[i], rand_value(), 6'(widths[i]));
    end
    issue(MODE_REWIND);
    for (int i = 0; i < k; i++) begin
      case (steps[i])
        MODE_WRITE:     issue(MODE_READ, $urandom, 6'(widths[i]));
        MODE_WRITE_VAR: issue(MODE_READ_VAR, $urandom, 6'($urandom));
        default:        issue(MODE_ALIGN, $urandom, 6'($urandom));
      endcase
    end
    // Reading on past the end of the record.
    if ($urandom_range(0, 2) == 0) issue(MODE_READ, $urandom, 6'($urandom_range(1, 32)));
  endtask

  initial begin
    int random_base;
    sb            = new();
    rst           = 1'b1;
    cmd_valid     = 1'b0;
    cmd           = '0;
    idle_on       = 1'b1;
    hold_receiver = 1'b0;
    sent          = 0;
    cycle_count   = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty store, width limits, saturation, zero-length and full-length
    // variable fields, and each way a variable-length read can fail.
    issue(MODE_READ, '0, 6'd8);
    issue(MODE_WRITE, 32'hFFFF_FFFF, 6'd0);
    issue(MODE_WRITE, 32'hFFFF_FFFF, 6'd32);
    issue(MODE_WRITE, 32'h0000_FFFF, 6'd5);
    issue(MODE_WRITE_VAR, 32'h0000_0000);
    issue(MODE_WRITE_VAR, 32'hFFFF_FFFF);
    issue(MODE_WRITE, 32'h1234_5678, 6'd33);
    issue(MODE_ALIGN);
    issue(MODE_REWIND);
    issue(MODE_READ, '0, 6'd0);
    issue(MODE_READ, '0, 6'd32);
    issue(MODE_READ, '0, 6'd5);
    issue(MODE_READ_VAR);
    issue(MODE_READ_VAR);
    issue(MODE_READ, '0, 6'd63);
    issue(MODE_READ, '0, 6'd8);
    issue(MODE_ALIGN);
    issue(MODE_CLEAR);
    issue(MODE_READ_VAR);
    issue(MODE_WRITE, 32'd40, 6'd6);
    issue(MODE_REWIND);
    issue(MODE_READ_VAR);
    issue(MODE_WRITE, 32'd20, 6'd6);
    issue(MODE_REWIND);
    issue(MODE_READ_VAR);
    issue(MODE_TO_END);

    // Fill the store to the last few bits, then run into the end in several ways.
    issue(MODE_CLEAR);
    repeat (STORE_BYTES / 4 - 1) issue(MODE_WRITE, $urandom, 6'd32);
    issue(MODE_WRITE_VAR, 32'h0040_0000 | (32'($urandom) & 32'h003F_FFFF));
    issue(MODE_WRITE, $urandom, 6'd4);
    issue(MODE_WRITE_VAR, 32'h0000_0000);
    issue(MODE_ALIGN);
    issue(MODE_WRITE, $urandom, 6'd1);
    issue(MODE_WRITE, $urandom, 6'd0);
    issue(MODE_READ, '0, 6'd1);
    issue(MODE_READ, '0, 6'd40);
    issue(MODE_REWIND);
    issue(MODE_READ, '0, 6'd40);
    issue(MODE_READ_VAR);
    issue(MODE_TO_END);
    issue(MODE_CLEAR);

    // Random part: mostly write-then-read-back records, some free noise.
    hold_receiver = 1'b1;
    random_base   = sent;
    while (sent - random_base < RANDOM_CMDS) begin
      idle_on = (sent - random_base) < RANDOM_CMDS - QUIET_TAIL;
      if ($urandom_range(0, 9) < 7) begin
        run_record();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          issue(mode_t'($urandom_range(0, 7)), $urandom, 6'($urandom_range(0, 63)));
        end
      end
    end
    idle_on = 1'b0;
    cmd_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d commands and checked %0d responses, store filled to its end once.",
             sent, sb.checked);
    $display("Per mode (write, read, write var, read var, align, rewind, end, clear): "
             , "%0d %0d %0d %0d %0d %0d %0d %0d", sb.mode_count[0], sb.mode_count[1],
             sb.mode_count[2], sb.mode_count[3], sb.mode_count[4], sb.mode_count[5],
             sb.mode_count[6], sb.mode_count[7]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
